// File: hdl/assert_macros.svh
// Assertion macros shared by the page-table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, off while reset is held.
`define LRP_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LRP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/lrp_pkg.sv
// Shared types and constants for the LRU page-frame table.
package lrp_pkg;

  localparam int IN_PAGE_W = 16;
  localparam int FRAME_IDX_W = 4;
  localparam int FAULT_W = 32;
  localparam int FC_W = 5;
  localparam logic [FC_W-1:0] FC_RESET = 5'd16;

  typedef struct packed {
    logic [IN_PAGE_W-1:0] page_number;
    logic                 start_of_string;
  } lrp_in_req_t;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic [FAULT_W-1:0]     fault_count;
  } lrp_out_res_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;    // take the request, clear table on start of string
    logic lookup;  // compare against resident frames
    logic select;  // pick hit, empty or LRU frame
    logic commit;  // update table and load the result register
  } lrp_cmd_t;

endpackage

// File: hdl/lru_page_replacement.sv
// Top level of the LRU page-frame table.
//
// Input channel in_valid/in_stall/in_req carries one page reference per
// request: a page number and a start-of-string flag that empties the table
// and zeroes the fault count before the reference is handled. The output
// channel out_valid/out_stall/out_res returns one result per request: hit
// flag, frame that now holds the page, and the saturating fault count.
// cfg_we/cfg_wdata set the number of frames in use (0 acts as 1, values
// above MAX_FRAMES act as MAX_FRAMES); write it only while the block is idle.
// An accepted request passes lookup and select; its update step then loads
// the output register once free. The sequencer runs accept, tag compare over
// frames in use, victim select, rank update, and holds one request at a time.
// A result waiting under out_stall does not block the next request; its
// update step holds until that result is taken.
// Reset empties the table at once through per-frame valid bits, sets the
// frame count to 16 and clears the fault count.
module lru_page_replacement import lrp_pkg::*; #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  lrp_in_req_t     in_req,
  output logic            out_valid,
  input  logic            out_stall,
  output lrp_out_res_t    out_res,
  input  logic            cfg_we,
  input  logic [FC_W-1:0] cfg_wdata
);

  lrp_cmd_t cmd;

  lrp_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lrp_datapath #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_res   (out_res)
  );

endmodule

// File: hdl/lrp_controller.sv
// Sequencer for the page-frame table: accept, lookup, select, update.
`include "assert_macros.svh"

module lrp_controller import lrp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output lrp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOOKUP = 4'b0010,
    S_SELECT = 4'b0100,
    S_UPDATE = 4'b1000
  } lrp_state_t;

  lrp_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       accept;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.load   = accept;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_LOOKUP;
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_SELECT;
      end
      S_SELECT: begin
        cmd.select = 1'b1;
        state_nxt  = S_UPDATE;
      end
      S_UPDATE: begin
        // hold until the result register can take the new result
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `LRP_ASSERT_NEXT(a_accept_to_lookup, clk, rst_n, in_valid && !in_stall, state_r == S_LOOKUP, "accepted request did not start lookup")
  `LRP_ASSERT_NEXT(a_select_to_update, clk, rst_n, state_r == S_SELECT, state_r == S_UPDATE, "select step did not advance to update")
  `LRP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "stalled result dropped")

endmodule

// File: hdl/lrp_datapath.sv
// Frame table, tag compare, victim select and rank update.
`include "assert_macros.svh"

module lrp_datapath import lrp_pkg::*; #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lrp_cmd_t         cmd,
  input  lrp_in_req_t      in_req,
  input  logic             cfg_we,
  input  logic [FC_W-1:0]  cfg_wdata,
  output lrp_out_res_t     out_res
);

  localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CMP_W   = (FRAME_W + 1 > FC_W) ? FRAME_W + 1 : FC_W;

  // Table
  logic [PAGE_BITS-1:0]  page_r    [MAX_FRAMES];
  logic [PAGE_BITS-1:0]  page_nxt  [MAX_FRAMES];
  logic [FRAME_W-1:0]    rank_r    [MAX_FRAMES];
  logic [FRAME_W-1:0]    rank_nxt  [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] valid_r, valid_nxt;
  logic [FAULT_W-1:0]    faults_r, faults_nxt;
  logic [FC_W-1:0]       frame_count_r, frame_count_nxt;

  // Per-request working registers
  logic [PAGE_BITS-1:0]  req_page_r, req_page_nxt;
  logic [MAX_FRAMES-1:0] match_r, match_nxt;
  logic [MAX_FRAMES-1:0] empty_r, empty_nxt;
  logic [MAX_FRAMES-1:0] use_r, use_nxt;
  logic [MAX_FRAMES-1:0] sel_oh_r, sel_oh_nxt;
  logic [FRAME_W-1:0]    slot_r, slot_nxt;
  logic [FRAME_W-1:0]    slot_rank_r, slot_rank_nxt;
  logic                  hit_r, hit_nxt;
  logic                  have_empty_r, have_empty_nxt;
  lrp_out_res_t          out_res_r, out_res_nxt;

  logic [FAULT_W-1:0]    faults_inc;
  logic                  was_valid;

  function automatic logic [PAGE_BITS-1:0] fit_page(input logic [IN_PAGE_W-1:0] p);
    logic [PAGE_BITS+IN_PAGE_W-1:0] w;
    w = (PAGE_BITS + IN_PAGE_W)'(p);
    return w[PAGE_BITS-1:0];
  endfunction

  function automatic logic [FRAME_IDX_W-1:0] fit_index(input logic [FRAME_W-1:0] s);
    logic [FRAME_W+FRAME_IDX_W-1:0] w;
    w = (FRAME_W + FRAME_IDX_W)'(s);
    return w[FRAME_IDX_W-1:0];
  endfunction

  // Lookup: compare against frames in use; a zero count still uses frame 0.
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      use_nxt[i]   = (i == 0) || (CMP_W'(i) < CMP_W'(frame_count_r));
      match_nxt[i] = use_nxt[i] && valid_r[i] && (page_r[i] == req_page_r);
      empty_nxt[i] = use_nxt[i] && !valid_r[i];
    end
  end

  // Select: lowest hit, else highest empty, else first oldest frame in use.
  always_comb begin
    logic [MAX_FRAMES-1:0] hit_oh;
    logic [MAX_FRAMES-1:0] empty_oh;
    logic [MAX_FRAMES-1:0] lru_oh;
    logic                  ok;
    hit_oh = match_r & (~match_r + MAX_FRAMES'(1));
    for (int i = 0; i < MAX_FRAMES; i++) begin
      empty_oh[i] = empty_r[i] && !(|(empty_r >> (i + 1)));
      ok = use_r[i];
      for (int j = 0; j < MAX_FRAMES; j++) begin
        if (use_r[j] && (j < i)) ok = ok && (rank_r[i] > rank_r[j]);
        if (use_r[j] && (j > i)) ok = ok && (rank_r[i] >= rank_r[j]);
      end
      lru_oh[i] = ok;
    end
    hit_nxt        = |match_r;
    have_empty_nxt = |empty_r;
    if (hit_nxt) sel_oh_nxt = hit_oh;
    else if (have_empty_nxt) sel_oh_nxt = empty_oh;
    else sel_oh_nxt = lru_oh;
    slot_nxt      = '0;
    slot_rank_nxt = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (sel_oh_nxt[i]) begin
        slot_nxt      = slot_nxt | FRAME_W'(i);
        slot_rank_nxt = slot_rank_nxt | rank_r[i];
      end
    end
  end

  assign faults_inc = (!hit_r && (faults_r != {FAULT_W{1'b1}})) ? faults_r + FAULT_W'(1)
                                                                : faults_r;
  assign was_valid  = hit_r || !have_empty_r;

  always_comb begin
    page_nxt        = page_r;
    rank_nxt        = rank_r;
    valid_nxt       = valid_r;
    faults_nxt      = faults_r;
    frame_count_nxt = frame_count_r;
    req_page_nxt    = req_page_r;
    out_res_nxt     = out_res_r;

    if (cfg_we) frame_count_nxt = cfg_wdata;

    if (cmd.load) begin
      req_page_nxt = fit_page(in_req.page_number);
      if (in_req.start_of_string) begin
        valid_nxt  = '0;
        faults_nxt = '0;
        for (int i = 0; i < MAX_FRAMES; i++) rank_nxt[i] = '0;
      end
    end

    if (cmd.commit) begin
      // a refill of a valid frame ages only the more recent ones
      for (int i = 0; i < MAX_FRAMES; i++) begin
        if (sel_oh_r[i]) begin
          rank_nxt[i]  = '0;
          valid_nxt[i] = 1'b1;
          if (!hit_r) page_nxt[i] = req_page_r;
        end else if (valid_r[i] && (!was_valid || (rank_r[i] < slot_rank_r))) begin
          rank_nxt[i] = rank_r[i] + FRAME_W'(1);
        end
      end
      faults_nxt              = faults_inc;
      out_res_nxt.hit         = hit_r;
      out_res_nxt.frame_index = fit_index(slot_r);
      out_res_nxt.fault_count = faults_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= '0;
      faults_r      <= '0;
      frame_count_r <= FC_RESET;
      for (int i = 0; i < MAX_FRAMES; i++) rank_r[i] <= '0;
    end else begin
      valid_r       <= valid_nxt;
      faults_r      <= faults_nxt;
      frame_count_r <= frame_count_nxt;
      rank_r        <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r     <= page_nxt;
    req_page_r <= req_page_nxt;
    out_res_r  <= out_res_nxt;
    if (cmd.lookup) begin
      match_r <= match_nxt;
      empty_r <= empty_nxt;
      use_r   <= use_nxt;
    end
    if (cmd.select) begin
      sel_oh_r     <= sel_oh_nxt;
      slot_r       <= slot_nxt;
      slot_rank_r  <= slot_rank_nxt;
      hit_r        <= hit_nxt;
      have_empty_r <= have_empty_nxt;
    end
  end

  assign out_res = out_res_r;

  `LRP_ASSERT_NEXT(a_sel_onehot, clk, rst_n, cmd.select, $onehot(sel_oh_r), "selected frame is not one-hot")
  `LRP_ASSERT_NEXT(a_commit_valid, clk, rst_n, cmd.commit, (valid_r & $past(sel_oh_r)) == $past(sel_oh_r), "updated frame not marked valid")
  `LRP_ASSERT_NEXT(a_faults_mono, clk, rst_n, !(cmd.load && in_req.start_of_string), faults_r >= $past(faults_r), "fault count went down without start of string")

endmodule
